// ----- hdl/hall_wheel_speed_meter_core_defines.svh -----
// Assertion macros shared by the hall wheel speed meter checker.
// Depends on nothing; included by the checker file only.
`ifndef HALL_WHEEL_SPEED_METER_CORE_DEFINES_SVH
`define HALL_WHEEL_SPEED_METER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HWSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HWSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hwsm_pkg.sv -----
// Package for the hall wheel speed meter: widths, constants, codes and the
// structs that join the controller and the datapath. Depends on nothing.
`default_nettype none

package hwsm_pkg;

    localparam int TIME_BITS     = 32;
    localparam int RPM_FRAC_BITS = 8;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int RPM_W      = 23;
    localparam int SPEED_W    = 20;
    localparam int FACTOR_W   = 16;
    localparam int PPR_W      = 5;

    localparam longint unsigned US_PER_MIN = 64'd60000000;
    localparam longint unsigned NUM        = US_PER_MIN << RPM_FRAC_BITS;
    localparam int NUM_W      = $clog2(NUM + 64'd1);
    localparam int DIVISOR_W  = TIME_BITS + PPR_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int PROD_W     = RPM_W + FACTOR_W;

    localparam logic [RPM_W-1:0]   RPM_MAX   = {RPM_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_SPIKE_LIMIT   = 3'd1,
        CFG_TIMEOUT       = 3'd2,
        CFG_TIMEOUT_FLOOR = 3'd3,
        CFG_PULSES_PER_REV = 3'd4,
        CFG_SPEED_FACTOR  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] debounce_us;
        logic [RPM_W-1:0]     spike_limit_q8;
        logic [TIME_BITS-1:0] timeout_us;
        logic [RPM_W-1:0]     timeout_floor_q8;
        logic [PPR_W-1:0]     pulses_per_rev;
        logic [FACTOR_W-1:0]  speed_factor_q16;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PULSE_CHK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PULSE_UPD,
        ST_QUERY_EVAL,
        ST_QUERY_OUT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic load_div;
        logic div_start;
        logic pulse_upd;
        logic query_eval;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pulse_ok;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/hwsm_cfg.sv -----
// Configuration register file of the hall wheel speed meter.
// Depends on hwsm_pkg for the register codes and the cfg_t struct.
`default_nettype none

module hwsm_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [hwsm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [hwsm_pkg::CFG_DATA_W-1:0] wr_data,
    output hwsm_pkg::cfg_t                       cfg
);
    import hwsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_DEBOUNCE:       cfg_next.debounce_us      = wr_data[TIME_BITS-1:0];
                CFG_SPIKE_LIMIT:    cfg_next.spike_limit_q8   = wr_data[RPM_W-1:0];
                CFG_TIMEOUT:        cfg_next.timeout_us       = wr_data[TIME_BITS-1:0];
                CFG_TIMEOUT_FLOOR:  cfg_next.timeout_floor_q8 = wr_data[RPM_W-1:0];
                CFG_PULSES_PER_REV: cfg_next.pulses_per_rev   = wr_data[PPR_W-1:0];
                CFG_SPEED_FACTOR:   cfg_next.speed_factor_q16 = wr_data[FACTOR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_us      <= TIME_BITS'(2000);
            cfg_reg.spike_limit_q8   <= RPM_W'(192000);
            cfg_reg.timeout_us       <= TIME_BITS'(5000000);
            cfg_reg.timeout_floor_q8 <= RPM_W'(76800);
            cfg_reg.pulses_per_rev   <= PPR_W'(2);
            cfg_reg.speed_factor_q16 <= FACTOR_W'(7117);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/hwsm_div.sv -----
// Restoring serial divider: the fixed rpm numerator over the scaled period,
// one quotient bit per cycle. Depends on hwsm_pkg for widths and the numerator.
`default_nettype none

module hwsm_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [hwsm_pkg::DIVISOR_W-1:0] divisor,
    output logic      [hwsm_pkg::NUM_W-1:0]     quotient,
    output logic                                done
);
    import hwsm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] div_reg, div_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_W);
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = NUM[NUM_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ----- hdl/hwsm_dp.sv -----
// Datapath of the hall wheel speed meter: pulse time and rpm state, period
// scaling, spike filter, timeout and speed product, output register.
// Depends on hwsm_pkg and hwsm_div.
`default_nettype none

module hwsm_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire hwsm_pkg::cfg_t                 cfg,
    input  wire hwsm_pkg::ctrl_cmd_t            cmd,
    output hwsm_pkg::dp_status_t                status,
    input  wire logic [hwsm_pkg::TIME_BITS-1:0] timestamp_us,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic      [hwsm_pkg::RPM_W-1:0]     rpm_q8,
    output logic      [hwsm_pkg::SPEED_W-1:0]   speed_kmh_q8,
    output logic                                timed_out
);
    import hwsm_pkg::*;

    logic [TIME_BITS-1:0] ts_reg;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [RPM_W-1:0]     rpm_reg, rpm_next;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic                 zero_period_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 tout_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [RPM_W-1:0]     out_rpm_reg;
    logic [SPEED_W-1:0]   out_speed_reg;
    logic                 out_tout_reg;

    logic [TIME_BITS-1:0] elapsed;
    logic [PPR_W-1:0]     ppr_eff;
    logic [NUM_W-1:0]     quotient;
    logic                 div_done;
    logic [NUM_W-1:0]     fresh;
    logic [NUM_W-1:0]     old_ext;
    logic [NUM_W-1:0]     jump;
    logic                 spike;
    logic [RPM_W-1:0]     fresh_sat;
    logic                 timeout_hit;
    logic [RPM_W-1:0]     rpm_query;
    logic [RPM_W-1:0]     speed_full;

    hwsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (divisor_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        // Time differences wrap naturally in the fixed width.
        elapsed = ts_reg - last_reg;
        ppr_eff = (cfg.pulses_per_rev == '0) ? PPR_W'(1) : cfg.pulses_per_rev;

        // The spike filter compares the unsaturated quotient.
        fresh     = zero_period_reg ? '0 : quotient;
        old_ext   = NUM_W'(rpm_reg);
        jump      = (fresh > old_ext) ? (fresh - old_ext) : (old_ext - fresh);
        spike     = (rpm_reg != '0) && (jump > NUM_W'(cfg.spike_limit_q8));
        fresh_sat = (fresh > NUM_W'(RPM_MAX)) ? RPM_MAX : fresh[RPM_W-1:0];

        timeout_hit = (elapsed > cfg.timeout_us) && (rpm_reg < cfg.timeout_floor_q8);
        rpm_query   = timeout_hit ? '0 : rpm_reg;

        speed_full = prod_reg[PROD_W-1:FACTOR_W];

        last_next = cmd.load_div ? ts_reg : last_reg;
        rpm_next  = rpm_reg;
        if (cmd.pulse_upd && !spike)
        begin
            rpm_next = fresh_sat;
        end
        else if (cmd.query_eval)
        begin
            rpm_next = rpm_query;
        end

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            rpm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            rpm_reg       <= rpm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            ts_reg <= timestamp_us;
        end
        if (cmd.load_div)
        begin
            divisor_reg     <= DIVISOR_W'(elapsed) * DIVISOR_W'(ppr_eff);
            zero_period_reg <= (elapsed == '0) || (64'(elapsed) > NUM);
        end
        if (cmd.query_eval)
        begin
            prod_reg <= PROD_W'(rpm_query) * PROD_W'(cfg.speed_factor_q16);
            tout_reg <= timeout_hit;
        end
        if (cmd.load_out)
        begin
            out_rpm_reg   <= rpm_reg;
            out_speed_reg <= (speed_full > RPM_W'(SPEED_MAX)) ?
                             SPEED_MAX : speed_full[SPEED_W-1:0];
            out_tout_reg  <= tout_reg;
        end
    end

    assign status.pulse_ok = (elapsed > cfg.debounce_us);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign rpm_q8       = out_rpm_reg;
    assign speed_kmh_q8 = out_speed_reg;
    assign timed_out    = out_tout_reg;

endmodule

`default_nettype wire

// ----- hdl/hwsm_ctrl.sv -----
// Controller of the hall wheel speed meter: sequences pulse and query work.
// Depends on hwsm_pkg for the state type and the command and status structs.
`default_nettype none

module hwsm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 func,
    output logic                      in_ready,
    input  wire hwsm_pkg::dp_status_t status,
    output hwsm_pkg::ctrl_cmd_t       cmd
);
    import hwsm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = func ? ST_QUERY_EVAL : ST_PULSE_CHK;
                end
            end
            ST_PULSE_CHK:
            begin
                // A pulse inside the debounce interval is dropped here.
                if (status.pulse_ok)
                begin
                    cmd.load_div = 1'b1;
                    state_next   = ST_DIV_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_PULSE_UPD;
                end
            end
            ST_PULSE_UPD:
            begin
                cmd.pulse_upd = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_QUERY_EVAL:
            begin
                cmd.query_eval = 1'b1;
                state_next     = ST_QUERY_OUT;
            end
            ST_QUERY_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/hall_wheel_speed_meter_core.sv -----
// Top level of the hall wheel speed meter core.
// Depends on hwsm_pkg, hwsm_cfg, hwsm_ctrl and hwsm_dp (with hwsm_div).
//
// Usage. The input channel (in_valid/in_ready, func, timestamp_us) carries one
// beat per event. A beat with func low is a hall pulse; it yields no result.
// A beat with func high is a speed query; it yields exactly one beat on the
// output channel (out_valid/out_ready, rpm_q8, speed_kmh_q8, timed_out).
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per beat; indexes above five are
// ignored. Write it only while the core is idle.
//
// Sequencing. The core works on one event at a time. A pulse inside the
// debounce window is dropped at the debounce check. For an accepted pulse the
// period is scaled by the pulse count, then a restoring divider forms the rpm
// one quotient bit per cycle. A query is evaluated, then its result goes into
// the output register, which raises the output beat in the same cycle.
//
// Reset clears the pulse time and the rpm to zero, loads the default register
// values and empties the output register. When the receiver stalls, the
// result waits in the output register and pulses are still taken; a second
// query waits in its last step until the pending beat is taken.
`default_nettype none

module hall_wheel_speed_meter_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            func,
    input  wire logic [hwsm_pkg::TIME_BITS-1:0]  timestamp_us,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [hwsm_pkg::RPM_W-1:0]      rpm_q8,
    output logic      [hwsm_pkg::SPEED_W-1:0]    speed_kmh_q8,
    output logic                                 timed_out,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hwsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hwsm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hwsm_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    hwsm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The controller decides when a beat is taken and steps the datapath.
    hwsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the pulse time, the rpm state and the output register.
    hwsm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .timestamp_us (timestamp_us),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .rpm_q8       (rpm_q8),
        .speed_kmh_q8 (speed_kmh_q8),
        .timed_out    (timed_out)
    );

endmodule

`default_nettype wire

// ----- hdl/hwsm_checker.sv -----
// Port-level checker for the hall wheel speed meter core, bound to the top.
// Depends on hwsm_pkg and hall_wheel_speed_meter_core_defines.svh.
`default_nettype none
`include "hall_wheel_speed_meter_core_defines.svh"

module hwsm_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            func,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [hwsm_pkg::RPM_W-1:0]      rpm_q8,
    input wire logic [hwsm_pkg::SPEED_W-1:0]    speed_kmh_q8,
    input wire logic                            timed_out
);
    import hwsm_pkg::*;

    logic in_take;

    assign in_take = in_valid && in_ready;

    `HWSM_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
    `HWSM_ASSERT_NEXT(a_pulse_no_result, clk, rst_n, in_take && !func && !out_valid, !out_valid, "pulse event produced a result")
    `HWSM_ASSERT_NEXT(a_query_busy, clk, rst_n, in_take && func, !in_ready, "query accepted back to back")
    `HWSM_ASSERT_NOW(a_timeout_zero, clk, rst_n, out_valid && timed_out, rpm_q8 == '0, "timeout result with nonzero rpm")
    `HWSM_ASSERT_NOW(a_speed_zero, clk, rst_n, out_valid && (rpm_q8 == '0), speed_kmh_q8 == '0, "zero rpm with nonzero speed")

endmodule

bind hall_wheel_speed_meter_core hwsm_checker u_hwsm_checker (.*);

`default_nettype wire

// ----- tb/sv/hall_wheel_speed_meter_core_checker.sv -----
// Checker for the hall wheel speed meter core: watches the three channels,
// predicts every speed report and compares it with the output beats.
// Depends on hwsm_pkg for widths, register indexes and the register struct.
`timescale 1ns / 1ps

module hall_wheel_speed_meter_core_checker
    import hwsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic                  func,
    input  wire logic [TIME_BITS-1:0]  timestamp_us,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [RPM_W-1:0]      rpm_q8,
    input  wire logic [SPEED_W-1:0]    speed_kmh_q8,
    input  wire logic                  timed_out,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         reports_pending
);

    typedef struct packed {
        logic               is_report;
        logic [RPM_W-1:0]   rpm;
        logic [SPEED_W-1:0] speed;
        logic               timed_out;
    } speed_report_t;

    cfg_t                 cfg_mirror;
    logic [TIME_BITS-1:0] last_pulse_t;
    logic [RPM_W-1:0]     rpm_now;
    speed_report_t        speed_reports_q[$];
    int                   mismatch_tally;

    // One event through the wheel meter; updates the mirrored state and
    // returns the report that a query produces.
    function automatic speed_report_t meter_event(input logic is_query,
                                                  input logic [TIME_BITS-1:0] ts);
        speed_report_t        rep;
        logic [TIME_BITS-1:0] elapsed;
        longint unsigned      period;
        longint unsigned      ppr;
        longint unsigned      fresh;
        longint unsigned      old_rpm;
        longint unsigned      jump;
        longint unsigned      rpm_wide;
        longint unsigned      factor;
        longint unsigned      speed;
        rep     = '0;
        elapsed = ts - last_pulse_t;
        period  = elapsed;
        if (!is_query) begin
            if (elapsed > cfg_mirror.debounce_us) begin
                ppr = cfg_mirror.pulses_per_rev;
                if (ppr == 0)
                    ppr = 1;
                if (period == 0 || period > NUM)
                    fresh = 0;
                else
                    fresh = NUM / (period * ppr);
                old_rpm = rpm_now;
                jump    = (fresh > old_rpm) ? fresh - old_rpm : old_rpm - fresh;
                last_pulse_t = ts;
                // The spike test looks at the unsaturated quotient.
                if (!(old_rpm != 0 && jump > cfg_mirror.spike_limit_q8))
                    rpm_now = (fresh > RPM_MAX) ? RPM_MAX : fresh[RPM_W-1:0];
            end
        end else begin
            rep.is_report = 1'b1;
            if (elapsed > cfg_mirror.timeout_us && rpm_now < cfg_mirror.timeout_floor_q8) begin
                rpm_now       = '0;
                rep.timed_out = 1'b1;
            end
            rpm_wide  = rpm_now;
            factor    = cfg_mirror.speed_factor_q16;
            speed     = (rpm_wide * factor) >> 16;
            rep.speed = (speed > SPEED_MAX) ? SPEED_MAX : speed[SPEED_W-1:0];
            rep.rpm   = rpm_now;
        end
        return rep;
    endfunction

    function automatic int field_differs(input string label, input longint unsigned want,
                                         input longint unsigned got);
        if (want == got)
            return 0;
        $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        speed_report_t rep;
        speed_report_t want;
        if (!rst_n) begin
            cfg_mirror.debounce_us      = 32'd2000;
            cfg_mirror.spike_limit_q8   = 23'd192000;
            cfg_mirror.timeout_us       = 32'd5000000;
            cfg_mirror.timeout_floor_q8 = 23'd76800;
            cfg_mirror.pulses_per_rev   = 5'd2;
            cfg_mirror.speed_factor_q16 = 16'd7117;
            last_pulse_t    = '0;
            rpm_now         = '0;
            mismatch_tally  = 0;
            speed_reports_q.delete();
            mismatches      <= 0;
            reports_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEBOUNCE:       cfg_mirror.debounce_us      = cfg_data;
                    CFG_SPIKE_LIMIT:    cfg_mirror.spike_limit_q8   = cfg_data[RPM_W-1:0];
                    CFG_TIMEOUT:        cfg_mirror.timeout_us       = cfg_data;
                    CFG_TIMEOUT_FLOOR:  cfg_mirror.timeout_floor_q8 = cfg_data[RPM_W-1:0];
                    CFG_PULSES_PER_REV: cfg_mirror.pulses_per_rev   = cfg_data[PPR_W-1:0];
                    CFG_SPEED_FACTOR:   cfg_mirror.speed_factor_q16 = cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
            // An output beat always belongs to an older query, so it is
            // retired before this edge's input beat is predicted.
            if (out_valid && out_ready) begin
                if (speed_reports_q.size() == 0) begin
                    $display("%0t: output beat with no report expected (rpm_q8 %0d)",
                             $time, rpm_q8);
                    mismatch_tally++;
                end else begin
                    want = speed_reports_q.pop_front();
                    mismatch_tally += field_differs("rpm_q8", want.rpm, rpm_q8);
                    mismatch_tally += field_differs("speed_kmh_q8", want.speed, speed_kmh_q8);
                    mismatch_tally += field_differs("timed_out", want.timed_out, timed_out);
                end
            end
            if (in_valid && in_ready) begin
                rep = meter_event(func, timestamp_us);
                if (rep.is_report)
                    speed_reports_q.push_back(rep);
            end
            mismatches      <= mismatch_tally;
            reports_pending <= speed_reports_q.size();
        end
    end

endmodule

// ----- tb/sv/hall_wheel_speed_meter_core_tb.sv -----
// Top of the hall wheel speed meter testbench: clock, reset, stimulus on the
// event and register channels, receiver stalls and the verdict.
// Depends on hwsm_pkg, the core and hall_wheel_speed_meter_core_checker.
`timescale 1ns / 1ps

module hall_wheel_speed_meter_core_tb;
    import hwsm_pkg::*;

    // Quiet time after the last report before registers are touched. A pulse
    // that yields no report keeps the core busy through the division and update.
    localparam int DRAIN_CYCLES = 64;
    // Watchdog on the whole run.
    localparam int LIMIT_CYCLES = 800000;

    // Register indexes that the core ignores.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  func;
    logic [TIME_BITS-1:0]  timestamp_us;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [RPM_W-1:0]      rpm_q8;
    logic [SPEED_W-1:0]    speed_kmh_q8;
    logic                  timed_out;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int reports_pending;
    int cycle_count = 0;

    // Stimulus-side copies of the written registers. They only shape the
    // timestamps; prediction lives entirely in the checker.
    logic [TIME_BITS-1:0] debounce_now;
    logic [TIME_BITS-1:0] timeout_now;
    // Time of the last pulse that was meant to be a good one.
    logic [TIME_BITS-1:0] pulse_cursor;
    // Beats left in the current sender burst.
    int burst_left = 0;

    always #5 clk = ~clk;

    hall_wheel_speed_meter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .timestamp_us (timestamp_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rpm_q8       (rpm_q8),
        .speed_kmh_q8 (speed_kmh_q8),
        .timed_out    (timed_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    hall_wheel_speed_meter_core_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .timestamp_us    (timestamp_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rpm_q8          (rpm_q8),
        .speed_kmh_q8    (speed_kmh_q8),
        .timed_out       (timed_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    // Watchdog. A hung handshake or a lost report ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("hall_wheel_speed_meter_core_tb: done, errors");
            $finish;
        end
    end

    // The receiver switches between stretches of full readiness, coin-flip
    // readiness and long stalls, so reports back up in the output register
    // while further pulses and queries arrive.
    always @(posedge clk) begin
        int rx_mode;
        int rx_left;
        if (rx_left <= 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Present one event beat and hold it until the core takes it. Valid is
    // left high so that a following beat can go out on the very next edge.
    task automatic send_event(input logic is_query, input logic [TIME_BITS-1:0] ts);
        in_valid     <= 1'b1;
        func         <= is_query;
        timestamp_us <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Bursts of back-to-back beats separated by random gaps.
    task automatic pace_sender();
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Stop sending and wait until every expected report has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Rewrite all six registers once the core has gone quiet. Data may carry
    // bits above a register's width; the core drops them.
    task automatic program_meter(input logic [31:0] debounce, input logic [31:0] spike,
                                 input logic [31:0] timeout, input logic [31:0] floor_q8,
                                 input logic [31:0] ppr, input logic [31:0] factor);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write(CFG_DEBOUNCE, debounce);
        cfg_write(CFG_SPIKE_LIMIT, spike);
        cfg_write(CFG_TIMEOUT, timeout);
        cfg_write(CFG_TIMEOUT_FLOOR, floor_q8);
        cfg_write(CFG_PULSES_PER_REV, ppr);
        cfg_write(CFG_SPEED_FACTOR, factor);
        cfg_valid    <= 1'b0;
        debounce_now = debounce;
        timeout_now  = timeout;
        @(posedge clk);
    endtask

    // Random traffic. Most beats are a plausible wheel: pulses one period
    // apart with a little jitter, and queries in between. The rest are
    // contact bounce, queries after a long silence and arbitrary times.
    task automatic run_phase(input int count, input int unsigned per_lo,
                             input int unsigned per_hi, input bit with_gaps);
        int unsigned          period;
        int unsigned          jitter;
        int unsigned          bounce_span;
        int                   pick;
        logic                 is_query;
        logic [TIME_BITS-1:0] ts;
        period = $urandom_range(per_lo, per_hi);
        for (int n = 0; n < count; n++) begin
            // Once per phase the sender holds off until the core has
            // delivered everything.
            if (n == count / 2)
                wait_drained();
            if ($urandom_range(0, 24) == 0)
                period = $urandom_range(per_lo, per_hi);
            jitter      = period / 32 + 1;
            bounce_span = (debounce_now > 50000) ? 50000 : debounce_now;
            pick        = $urandom_range(0, 99);
            if (pick < 50) begin
                is_query     = 1'b0;
                ts           = pulse_cursor + period - jitter + $urandom_range(0, 2 * jitter);
                pulse_cursor = ts;
            end else if (pick < 60) begin
                is_query = 1'b0;
                ts       = pulse_cursor + $urandom_range(0, bounce_span);
            end else if (pick < 64) begin
                is_query     = 1'b0;
                ts           = $urandom();
                pulse_cursor = ts;
            end else if (pick < 86) begin
                is_query = 1'b1;
                ts       = pulse_cursor + $urandom_range(0, period);
            end else if (pick < 95) begin
                is_query = 1'b1;
                ts       = pulse_cursor + timeout_now + $urandom_range(1, 5000);
            end else begin
                is_query = 1'b1;
                ts       = $urandom();
            end
            if (with_gaps)
                pace_sender();
            send_event(is_query, ts);
        end
    endtask

    localparam logic PULSE = 1'b0;
    localparam logic QUERY = 1'b1;

    initial begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        func         <= PULSE;
        timestamp_us <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_DEBOUNCE;
        cfg_data     <= '0;
        debounce_now = 32'd2000;
        timeout_now  = 32'd5000000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part on the reset register values.
        send_event(QUERY, 32'd0);           // nothing measured yet, no timeout
        send_event(QUERY, 32'hFFFF_FFFF);   // long silence with zero rpm times out
        send_event(PULSE, 32'd100);         // inside the debounce window
        send_event(PULSE, 32'd10000);       // first reading, taken from zero rpm
        send_event(QUERY, 32'd10001);
        send_event(PULSE, 32'd20000);       // same period again
        send_event(PULSE, 32'd20500);       // bounce
        send_event(PULSE, 32'd30000);
        send_event(PULSE, 32'd32000);       // exactly the debounce interval: rejected
        send_event(PULSE, 32'd40001);
        send_event(PULSE, 32'd42002);       // far too fast: spike, rpm is kept
        send_event(QUERY, 32'd42100);
        send_event(PULSE, 32'hFFFF_F000);   // far too slow: spike again
        send_event(PULSE, 32'h0000_16F0);   // period across the timestamp wrap
        send_event(QUERY, 32'h0000_2000);
        send_event(QUERY, 32'h0000_3000);

        // Directed part on extreme registers: zero debounce, widest spike
        // limit, zero timeout with the top floor, pulse count zero (taken as
        // one) and the largest speed factor. The ignored indexes go out too.
        program_meter(32'd0, 32'h007F_FFFF, 32'd0, 32'h007F_FFFF, 32'd0, 32'h0000_FFFF);
        cfg_write(CFG_SPARE_LO, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE_HI, 32'h5A5A_A5A5);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_event(PULSE, 32'h0010_0000);
        send_event(QUERY, 32'h0010_0005);   // timeout zeroes the rpm
        send_event(PULSE, 32'h0010_0006);   // huge reading from zero, saturates
        send_event(QUERY, 32'h0010_0006);   // saturated speed
        send_event(PULSE, 32'h0010_0007);   // unsaturated jump beyond the limit
        send_event(PULSE, 32'h0010_0007);   // zero elapsed time never passes
        send_event(QUERY, 32'h0010_0007);
        pulse_cursor = 32'h0020_0000;

        // Random phases over several register settings.
        program_meter(32'd2000, 32'd192000, 32'd5000000, 32'd76800, 32'd2, 32'd7117);
        run_phase(75, 2500, 60000, 1'b1);

        program_meter(32'd100, $urandom_range(0, 8388607), 32'd1000000, 32'h007F_FFFF,
                      32'd16, 32'h0000_FFFF);
        run_phase(75, 150, 20000, 1'b1);

        // No sender gaps here, with a zero spike limit and 31 pulses per turn.
        program_meter(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd31, 32'd0);
        run_phase(75, 1, 5000, 1'b0);

        program_meter($urandom_range(0, 3000), $urandom(), $urandom_range(0, 2000000),
                      $urandom(), $urandom(), $urandom());
        cfg_write(CFG_SPARE_LO, $urandom());
        cfg_write(CFG_SPARE_HI, $urandom());
        cfg_valid <= 1'b0;
        @(posedge clk);
        run_phase(75, 1000, 100000, 1'b1);

        // Slow wheel: one magnet, long periods, a short timeout and a high floor.
        program_meter(32'd500, 32'h007F_FFFF, 32'd300000, 32'd307200, 32'd1, 32'd30000);
        run_phase(75, 100000, 3000000, 1'b1);

        // Largest debounce: no pulse can ever be taken.
        program_meter(32'hFFFF_FFFF, 32'd192000, 32'hFFFF_FFFF, 32'd76800, 32'd2, 32'd7117);
        run_phase(40, 2000, 50000, 1'b1);

        program_meter($urandom_range(0, 1500), $urandom(), $urandom_range(0, 8000000),
                      $urandom(), $urandom_range(1, 16), $urandom());
        run_phase(35, 1600, 80000, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && reports_pending == 0)
            $display("hall_wheel_speed_meter_core_tb: done, clean");
        else
            $display("hall_wheel_speed_meter_core_tb: done, errors");
        $finish;
    end

endmodule
